@@ hw/rtl/frs_pkg.sv @@
// Shared constants and types of the Floyd random sampler.
`timescale 1ns / 1ps

package frs_pkg;

    localparam int CFG_W       = 11;   // width of both configuration registers
    localparam int CFG_ADDR_W  = 1;
    localparam int WORD_W      = 31;   // width of the random_value field
    localparam int IN_TDATA_W  = 32;
    localparam int INDEX_W     = 10;   // width of the index field
    localparam int OUT_TDATA_W = 16;
    localparam int EPOCH_W     = 8;    // sample tag stored per used-map entry

    localparam int DEF_MAX_POPULATION = 1024;
    localparam int DEF_RANDOM_BITS    = 31;

    localparam logic [CFG_ADDR_W-1:0] CFG_POPULATION = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE     = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_START,
        S_DIV,
        S_READ,
        S_CHECK,
        S_OUT
    } t_state;

    // Handshake between the sequencer and the serial remainder unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_stat;

endpackage

@@ hw/rtl/frs_mod.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps

module frs_mod
    import frs_pkg::*;
#(
    parameter int WB = DEF_RANDOM_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WB-1:0]    i_word,
    input  logic [CFG_W:0]   i_divisor,
    output logic [CFG_W-1:0] o_rem,
    output t_mod_stat        o_stat
);

    localparam int CNT_W = $clog2(WB + 1);

    logic [WB-1:0]    r_word;
    logic [CFG_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [CFG_W:0]   n_shift;
    logic [CFG_W:0]   n_diff;
    logic [CFG_W-1:0] n_rem;

    // The partial remainder stays below the divisor, so it fits in CFG_W bits.
    always_comb begin
        n_shift = {r_rem, r_word[WB-1]};
        n_diff  = n_shift - i_divisor;
        n_rem   = (n_shift >= i_divisor) ? n_diff[CFG_W-1:0] : n_shift[CFG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_word <= i_word;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_word <= {r_word[WB-2:0], 1'b0};
            r_rem  <= n_rem;
        end
    end

    assign o_rem       = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

@@ hw/rtl/floyd_random_sampler.sv @@
// Top level of the Floyd random sampler: sequencer, used-map memory and result register.
`timescale 1ns / 1ps

// Channel      Direction  Payload (lowest bit first)
// s_axis       in         tdata: random_value[30:0], one zero pad bit
// m_axis       out        tdata: index[9:0], six zero pad bits; tlast: last;
//                         tuser: size_error
// cfg          in         index 0 population_size, index 1 sample_size, 11 bits
//
// A transaction passes through these steps: accept, start, the bit-serial
// remainder unit (until its done flag is seen), one memory read, one
// check-and-mark step and the load of the result register. The serial
// remainder by (position + 1) is the slowest of these steps; a size-error
// transaction goes from accept straight to the result register. The used-map
// holds a sample tag per entry rather than a bit, so a new sample only bumps the
// tag; when the tag wraps (every 255 samples, and at the first sample after
// reset) a clearing pass over all MAX_POPULATION entries runs before that draw.
// Reset is synchronous and active low. A stalled result sits in the output
// register while the next transaction is already accepted and computed.

module floyd_random_sampler
    import frs_pkg::*;
#(
    parameter int MAX_POPULATION = DEF_MAX_POPULATION,
    parameter int RANDOM_BITS    = DEF_RANDOM_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // random_value[30:0], bit 31 unused
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // index[9:0], bits 15:10 zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tlast,
    // size_error
    output logic                   o_m_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    // Bits of the random word that take part in a draw.
    localparam int WB = (RANDOM_BITS < WORD_W) ? RANDOM_BITS : WORD_W;
    localparam int AW = $clog2(MAX_POPULATION);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_pop;
    logic [CFG_W-1:0]   r_sample;
    logic [CFG_W-1:0]   r_position;
    logic [CFG_W-1:0]   r_drawn;
    logic [EPOCH_W-1:0] r_epoch;
    logic [AW-1:0]      r_clr;
    logic [WB-1:0]      r_word;

    // Result being built, and the output register towards m_axis.
    logic [INDEX_W-1:0] r_res_index;
    logic               r_res_last;
    logic               r_res_err;
    logic [INDEX_W-1:0] r_out_index;
    logic               r_out_last;
    logic               r_out_err;
    logic               r_out_valid;

    // Used-map: each entry holds the tag of the sample that last marked it.
    logic [EPOCH_W-1:0] r_map [MAX_POPULATION];
    logic [EPOCH_W-1:0] r_tag;

    logic               mod_start;
    logic [CFG_W:0]     mod_divisor;
    logic [CFG_W-1:0]   mod_rem;
    t_mod_stat          mod_stat;

    logic               in_accept;
    logic               out_free;
    logic               cfg_bad;
    logic               map_we;
    logic [AW-1:0]      map_waddr;
    logic [EPOCH_W-1:0] map_wdata;
    logic [CFG_W-1:0]   chosen;
    logic [CFG_W-1:0]   drawn_inc;

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_out_valid || i_m_axis_tready;

    // A sample is impossible when a register is zero, the population exceeds
    // the map, or more indices are asked for than exist.
    assign cfg_bad = (r_sample == '0) || (r_pop == '0) ||
                     (32'(r_pop) > 32'(MAX_POPULATION)) || (r_sample > r_pop);

    assign mod_divisor = {1'b0, r_position} + 1'b1;

    // An entry tagged with the current sample is already taken; Floyd's rule
    // then falls back to the position itself, which is never taken yet.
    assign chosen    = (r_tag == r_epoch) ? r_position : mod_rem;
    assign drawn_inc = r_drawn + 1'b1;

    frs_mod #(
        .WB(WB)
    ) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mod_start),
        .i_word   (r_word),
        .i_divisor(mod_divisor),
        .o_rem    (mod_rem),
        .o_stat   (mod_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        mod_start       = 1'b0;
        map_we          = 1'b0;
        map_waddr       = AW'(chosen);
        map_wdata       = r_epoch;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    if (cfg_bad) begin
                        n_state = S_OUT;
                    end else if (r_drawn == '0 && r_epoch == EPOCH_LAST) begin
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr;
                map_wdata = '0;
                if (r_clr == AW'(MAX_POPULATION - 1)) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                mod_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (mod_stat.done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                map_we  = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers: configuration, sample progress and the sample tag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop    <= CFG_W'(1024);
            r_sample <= CFG_W'(1);
            r_drawn  <= '0;
            r_epoch  <= EPOCH_LAST;
            r_clr    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_POPULATION: r_pop    <= i_cfg_data;
                    CFG_SAMPLE:     r_sample <= i_cfg_data;
                    default: ;
                endcase
                // Any register write abandons the sample in progress.
                r_drawn <= '0;
            end else if (in_accept && cfg_bad) begin
                r_drawn <= '0;
            end else if (in_accept && r_drawn == '0) begin
                r_epoch <= (r_epoch == EPOCH_LAST) ? EPOCH_W'(1) : r_epoch + 1'b1;
                r_clr   <= '0;
            end else if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end else if (r_state == S_CHECK) begin
                r_drawn <= (drawn_inc >= r_sample) ? '0 : drawn_inc;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_word <= i_s_axis_tdata[WB-1:0];
            if (cfg_bad) begin
                r_res_index <= '0;
                r_res_last  <= 1'b1;
                r_res_err   <= 1'b1;
            end
            if (r_drawn == '0) begin
                r_position <= r_pop - r_sample;
            end
        end else if (r_state == S_CHECK) begin
            r_res_index <= chosen[INDEX_W-1:0];
            r_res_last  <= (drawn_inc >= r_sample);
            r_res_err   <= 1'b0;
            r_position  <= r_position + 1'b1;
        end
    end

    // Used-map memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_waddr] <= map_wdata;
        end
        r_tag <= r_map[AW'(mod_rem)];
    end

    // Output register towards m_axis.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_index <= r_res_index;
            r_out_last  <= r_res_last;
            r_out_err   <= r_res_err;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - INDEX_W)'(0), r_out_index};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_err;

endmodule

@@ tb/sv/floyd_random_sampler_checker.sv @@
`timescale 1ns / 1ps
// Checker of the Floyd random sampler: predicts each drawn index and compares every result.

module floyd_random_sampler_checker
    import frs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // random_value[30:0], bit 31 zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                   i_s_axis_tvalid,
    input  logic                   i_s_axis_tready,
    // index[9:0], bits 15:10 zero
    input  logic [OUT_TDATA_W-1:0] i_m_axis_tdata,
    input  logic                   i_m_axis_tlast,
    // size_error
    input  logic                   i_m_axis_tuser,
    input  logic                   i_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               last;
        logic               size_error;
    } t_draw;

    logic [CFG_W-1:0]              population;
    logic [CFG_W-1:0]              sample;
    logic [CFG_W-1:0]              cursor;
    logic [CFG_W-1:0]              drawn;
    logic [DEF_MAX_POPULATION-1:0] taken;
    t_draw                         awaited_draws [$];

    // One step of Floyd's method; updates the sampler state held here.
    function automatic t_draw draw_index(input logic [WORD_W-1:0] word);
        t_draw       d;
        logic [31:0] pick;
        if (sample == '0 || population == '0 ||
            population > CFG_W'(DEF_MAX_POPULATION) || sample > population) begin
            drawn = '0;
            d.index = '0;
            d.last = 1'b1;
            d.size_error = 1'b1;
            return d;
        end
        if (drawn == '0) begin
            taken = '0;
            cursor = population - sample;
        end
        pick = {1'b0, word} % (32'(cursor) + 32'd1);
        if (pick >= DEF_MAX_POPULATION || taken[pick])
            pick = 32'(cursor);
        if (pick < DEF_MAX_POPULATION)
            taken[pick] = 1'b1;
        cursor = cursor + 1'b1;
        drawn = drawn + 1'b1;
        d.index = pick[INDEX_W-1:0];
        d.last = (drawn >= sample);
        d.size_error = 1'b0;
        if (d.last)
            drawn = '0;
        return d;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_draw              want;
        logic [INDEX_W-1:0] got_index;
        if (!i_rst_n) begin
            population = CFG_W'(DEF_MAX_POPULATION);
            sample = CFG_W'(1);
            taken = '0;
            cursor = population - sample;
            drawn = '0;
            awaited_draws.delete();
            o_fail_count = 0;
        end else begin
            // Results first: a result can never belong to an item accepted at the same edge.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_index = i_m_axis_tdata[INDEX_W-1:0];
                if (awaited_draws.size() == 0) begin
                    $error("unexpected result: index %0d, last %0b, size_error %0b",
                           got_index, i_m_axis_tlast, i_m_axis_tuser);
                    o_fail_count++;
                end else begin
                    want = awaited_draws.pop_front();
                    if (got_index !== want.index) begin
                        $error("index: expected %0d, actual %0d", want.index, got_index);
                        o_fail_count++;
                    end
                    if (i_m_axis_tlast !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, i_m_axis_tlast);
                        o_fail_count++;
                    end
                    if (i_m_axis_tuser !== want.size_error) begin
                        $error("size_error: expected %0b, actual %0b",
                               want.size_error, i_m_axis_tuser);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_POPULATION: begin
                        population = i_cfg_data;
                        drawn = '0;
                    end
                    CFG_SAMPLE: begin
                        sample = i_cfg_data;
                        drawn = '0;
                    end
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                awaited_draws.push_back(draw_index(i_s_axis_tdata[WORD_W-1:0]));
        end
        o_pending = awaited_draws.size();
    end

endmodule

@@ tb/sv/floyd_random_sampler_test.sv @@
`timescale 1ns / 1ps
// Top of the Floyd random sampler testbench: clock, reset, stimulus, stalls and verdict.

module floyd_random_sampler_test;
    import frs_pkg::*;

    // Cycles without any transaction before the run is declared hung. The worst
    // honest gap is a clearing pass of the used-map followed by a full draw and
    // a long receiver stall, so this leaves a wide margin.
    localparam int STALL_LIMIT  = 20000;
    // Cycles to watch the result channel once everything has arrived, so that a
    // stray extra result would still be caught.
    localparam int DRAIN_CYCLES = 80;
    localparam int PLAN_LEN     = 12;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    // random_value[30:0], bit 31 zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // index[9:0], bits 15:10 zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    // size_error
    logic                   m_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = CFG_POPULATION;
    logic [CFG_W-1:0]       cfg_data = '0;

    int send_idle_pct = 23;
    int recv_idle_pct = 46;
    int idle_cycles = 0;
    int fail_count;
    int pending;

    // Random phases: population, sample size and number of draws. The mix keeps
    // most draws on small samples, reaches the ends of both registers, walks a
    // largest sample part of the way before abandoning it, and includes the
    // configurations that can only produce the size error.
    int plan_pop   [PLAN_LEN] = '{1024, 16, 1024,  1, 37, 1024, 2, 1100,  9, 64, 1023, 200};
    int plan_samp  [PLAN_LEN] = '{   1,  5, 1024,  1, 37,    3, 1, 1023, 10, 17,    1,  50};
    int plan_count [PLAN_LEN] = '{ 200, 120, 120, 40, 111,  90, 60,  15, 15, 136, 100, 100};

    floyd_random_sampler uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tlast  (m_axis_tlast),
        .o_m_axis_tuser  (m_axis_tuser),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    floyd_random_sampler_checker draw_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tlast  (m_axis_tlast),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The receiver decides afresh every cycle whether to stall, so stalls land
    // on every phase of the block's work, including while a result is waiting
    // in the output register and the next transaction is already in flight.
    always @(posedge clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: any transaction on either stream restarts the count.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Half of the words behave like real random numbers, and a good share are
    // small words, so that the remainder often lands on an index already taken,
    // which forces the fallback to the current position.
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 3))
            0, 1:    random_word = WORD_W'($urandom());
            2:       random_word = WORD_W'($urandom_range(0, 63));
            default: random_word = $urandom_range(0, 1) ? '1 : '0;
        endcase
    endfunction

    // Offers one word and returns at the edge where the transaction happens.
    // tvalid is left high so that back-to-back words need no second assignment
    // in the same time step.
    task automatic send_word(input logic [WORD_W-1:0] word);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_TDATA_W - WORD_W){1'b0}}, word};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Withdraws the sender and waits until every expected result has been taken.
    // Each word produces exactly one result, so the block is idle at that point.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Leaves the write enable high; the caller lowers it after its last write.
    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic write_config(input int pop, input int samp);
        wait_drained();
        write_register(CFG_POPULATION, CFG_W'(pop));
        write_register(CFG_SAMPLE, CFG_W'(samp));
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int p;
        int k;
        int pop;
        int samp;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: population 1024, one draw per sample. The first
        // draw also sits behind the used-map clearing pass after reset.
        send_word('0);
        send_word('1);
        send_word(WORD_W'(1023));
        send_word(WORD_W'(1024));

        // Smallest population: only index zero can ever come out.
        write_config(1, 1);
        send_word('1);
        send_word('0);

        // Sample equal to the population with all-zero words: every draw after
        // the first collides and falls back to the position, then a new sample.
        write_config(4, 4);
        repeat (5) send_word('0);

        // Sample larger than the population.
        write_config(5, 6);
        send_word('1);
        send_word(WORD_W'(12345));

        // Zero population, population beyond the largest supported and zero
        // sample size must all give the size error.
        write_config(0, 3);
        send_word(WORD_W'(7));
        write_config(1500, 3);
        send_word(WORD_W'(7));
        write_config(10, 0);
        send_word(WORD_W'(7));

        // A write in the middle of a sample abandons it; the next word starts afresh.
        write_config(8, 4);
        send_word(WORD_W'(3));
        send_word(WORD_W'(5));
        wait_drained();
        write_register(CFG_SAMPLE, CFG_W'(4));
        cfg_we <= 1'b0;
        repeat (4) send_word(WORD_W'($urandom_range(0, 15)));

        // Random part. The receiver idles more than the sender at first, then
        // the other way round, and finally neither side holds back.
        for (p = 0; p < PLAN_LEN; p++) begin
            if (p == 4) begin
                send_idle_pct = 46;
                recv_idle_pct = 23;
            end else if (p == 10) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_config(plan_pop[p], plan_samp[p]);
            for (k = 0; k < plan_count[p]; k++)
                send_word(random_word());
        end

        // A handful of random configurations with modest sample sizes.
        for (p = 0; p < 6; p++) begin
            pop = $urandom_range(1, 1024);
            samp = $urandom_range(1, (pop < 64) ? pop : 64);
            write_config(pop, samp);
            for (k = 0; k < 25; k++)
                send_word(random_word());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/frs_pkg.sv
hw/rtl/frs_mod.sv
hw/rtl/floyd_random_sampler.sv
tb/sv/floyd_random_sampler_checker.sv
tb/sv/floyd_random_sampler_test.sv
